>>> sv/snpce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snpce_pkg
// Shared constants, command codes and controller/datapath types of the
// SNP combination enumerator.
// ----------------------------------------------------------------------------
package snpce_pkg;

    localparam int SNP_COUNT      = 65536;
    localparam int IDS_PER_BUFFER = 4096;
    localparam int AW             = (SNP_COUNT > 1) ? $clog2(SNP_COUNT) : 1;
    localparam int FCW            = $clog2(IDS_PER_BUFFER + 1);

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_NEXT  = 2'd1;
    localparam logic [1:0] CMD_ABORT = 2'd2;

    localparam logic [2:0] REG_ORDER = 3'd0;
    localparam logic [2:0] REG_RNG_A = 3'd1;
    localparam logic [2:0] REG_RNG_B = 3'd2;
    localparam logic [2:0] REG_RNG_C = 3'd3;
    localparam logic [2:0] REG_SKP_A = 3'd4;
    localparam logic [2:0] REG_SKP_B = 3'd5;
    localparam logic [2:0] REG_SKP_C = 3'd6;
    localparam logic [2:0] REG_MDIST = 3'd7;

    // Datapath evaluation of the current loop position
    typedef struct packed {
        logic a_end;     // outer loop exhausted
        logic b_end;     // middle loop exhausted
        logic c_end;     // inner loop exhausted
        logic a_skip;    // pair mode: a excluded
        logic ab_bad;    // (a,b) rejected (skip or distance)
        logic bc_bad;    // (b,c) rejected
        logic in_b;
        logic in_c;
        logic done;
        logic triple;
    } t_dp_status;

    // Controller commands to the datapath
    typedef struct packed {
        logic restart;
        logic load;      // write table entry
        logic rd_ab;     // read table at a and b
        logic rd_bc;     // read table at b and c
        logic enter_a;   // swaps, set b, set in_b
        logic adv_a;     // leave b loop, a++
        logic enter_b;   // set c, set in_c (triple)
        logic adv_b;     // b++ (clears in_c)
        logic adv_c;     // c++
        logic emit;      // deliver tuple from current indices
        logic fin;       // set done
    } t_dp_cmd;

endpackage : snpce_pkg
`default_nettype wire

>>> sv/snp_combination_enumerator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snp_combination_enumerator_core
// Top level of the SNP pair/triple enumerator.
// ----------------------------------------------------------------------------
// A load item writes one table entry and returns nothing. A next item
// returns one result: a combination or the finished mark. The controller
// makes one loop move per cycle while no result waits. A candidate pair
// (a,b) or (b,c) is handled in order: the registered table read is issued
// first, then the distance filter is applied to the read data. Each skipped
// outer index, exhausted loop or new outer index adds a loop move, and each
// rejected candidate adds a table read and a filter step. The result is
// held until it is taken, and the next item is not accepted before that.
// Abort answers finished in the cycle after it is taken. Any register write
// restarts the run; the tables keep their contents.
module snp_combination_enumerator_core import snpce_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [33:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [15:0] i_entry_index,
    input  wire logic [7:0]  i_entry_chromosome,
    input  wire logic [31:0] i_entry_position,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_first_id,
    output logic [15:0]      o_second_id,
    output logic [15:0]      o_third_id,
    output logic             o_has_tuple,
    output logic             o_buffer_end,
    output logic             o_finished
);
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    snpce_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_valid(i_valid), .o_ready(o_ready), .i_command(i_command),
        .o_valid(o_valid), .i_ready(i_ready),
        .i_status(w_status), .o_cmd(w_cmd));

    snpce_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data), .i_cmd(w_cmd),
        .i_entry_index(i_entry_index), .i_entry_chromosome(i_entry_chromosome),
        .i_entry_position(i_entry_position), .o_status(w_status),
        .o_first_id(o_first_id), .o_second_id(o_second_id),
        .o_third_id(o_third_id), .o_has_tuple(o_has_tuple),
        .o_buffer_end(o_buffer_end), .o_finished(o_finished));
endmodule : snp_combination_enumerator_core
`default_nettype wire

>>> sv/snpce_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snpce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module snpce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule : snpce_ram
`default_nettype wire

>>> sv/snpce_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snpce_datapath
// Configuration registers, loop indices, exchanged borders, SNP tables and
// the distance filter of the enumerator.
// ----------------------------------------------------------------------------
module snpce_datapath import snpce_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [33:0]         i_cfg_data,
    input  wire t_dp_cmd             i_cmd,
    input  wire logic [15:0]         i_entry_index,
    input  wire logic [7:0]          i_entry_chromosome,
    input  wire logic [31:0]         i_entry_position,
    output t_dp_status               o_status,
    output logic [15:0]              o_first_id,
    output logic [15:0]              o_second_id,
    output logic [15:0]              o_third_id,
    output logic                     o_has_tuple,
    output logic                     o_buffer_end,
    output logic                     o_finished
);
    logic [1:0]  r_order;
    logic [33:0] r_rng_a, r_rng_b, r_rng_c, r_skp_a, r_skp_b, r_skp_c;
    logic [31:0] r_mdist;
    logic [16:0] r_a, r_b, r_c;
    logic [16:0] r_end [3];
    logic [33:0] r_skp [3];
    logic        r_done, r_inb, r_inc, r_swbc;
    logic [FCW-1:0] r_fill;
    logic [15:0] r_o1, r_o2, r_o3;
    logic        r_oh, r_obe, r_ofin;

    function automatic logic in_skip(input logic [16:0] i, input logic [33:0] s);
        return (i >= s[16:0]) && (i < s[33:17]);
    endfunction

    function automatic logic [16:0] max17(input logic [16:0] x, input logic [16:0] y);
        return (x > y) ? x : y;
    endfunction

    // Table read ports: two memories per table, one per compared member
    logic [16:0] w_p, w_q;
    logic [7:0]  w_cp, w_cq;
    logic [31:0] w_pp, w_pq;
    logic        r_p_ok, r_q_ok;
    logic        w_we;

    assign w_p  = i_cmd.rd_bc ? r_b : r_a;
    assign w_q  = i_cmd.rd_bc ? r_c : r_b;
    assign w_we = i_cmd.load && ({1'b0, i_entry_index} < 17'(SNP_COUNT));

    snpce_ram #(.WIDTH(40), .DEPTH(SNP_COUNT)) u_tab_p (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(i_entry_index[AW-1:0]),
        .i_wdata({i_entry_chromosome, i_entry_position}),
        .i_raddr(w_p[AW-1:0]), .o_rdata({w_cp, w_pp}));
    snpce_ram #(.WIDTH(40), .DEPTH(SNP_COUNT)) u_tab_q (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(i_entry_index[AW-1:0]),
        .i_wdata({i_entry_chromosome, i_entry_position}),
        .i_raddr(w_q[AW-1:0]), .o_rdata({w_cq, w_pq}));

    // Out-of-table reads answer chromosome 0, position 0
    logic [7:0]  w_chp, w_chq;
    logic [31:0] w_psp, w_psq, w_diff;
    logic        w_far;
    assign w_chp  = r_p_ok ? w_cp : 8'd0;
    assign w_chq  = r_q_ok ? w_cq : 8'd0;
    assign w_psp  = r_p_ok ? w_pp : 32'd0;
    assign w_psq  = r_q_ok ? w_pq : 32'd0;
    assign w_diff = w_psq - w_psp;
    assign w_far  = (r_mdist == 32'd0) || (w_chp != w_chq) || (w_diff >= r_mdist);

    // Pair-mode exchange of A and B
    logic [16:0] w_end_a, w_end_b, w_first_b, w_first_c, w_right_a, w_right_b;
    logic        w_sw;
    logic [33:0] w_ex_a, w_ex_b;
    assign w_end_a   = r_rng_a[33:17];
    assign w_end_b   = r_rng_b[33:17];
    assign w_first_b = r_rng_b[16:0];
    assign w_first_c = r_rng_c[16:0];
    assign w_right_a = (w_end_a < w_end_b) ? w_end_a : w_end_b;
    assign w_sw      = (w_end_b < w_end_a) && (r_a >= w_first_b);
    assign w_ex_a    = w_sw ? r_skp_b : r_skp_a;
    assign w_ex_b    = w_sw ? r_skp_a : r_skp_b;
    assign w_right_b = w_sw ? w_end_a : w_end_b;

    logic w_triple;
    assign w_triple = (r_order == 2'd3);

    // Register values after this cycle's write, so a restart sees the new ones
    logic [33:0] n_rng_a, n_rng_b, n_rng_c, n_skp_a, n_skp_b, n_skp_c;
    assign n_rng_a = (i_cfg_we && i_cfg_index == REG_RNG_A) ? i_cfg_data : r_rng_a;
    assign n_rng_b = (i_cfg_we && i_cfg_index == REG_RNG_B) ? i_cfg_data : r_rng_b;
    assign n_rng_c = (i_cfg_we && i_cfg_index == REG_RNG_C) ? i_cfg_data : r_rng_c;
    assign n_skp_a = (i_cfg_we && i_cfg_index == REG_SKP_A) ? i_cfg_data : r_skp_a;
    assign n_skp_b = (i_cfg_we && i_cfg_index == REG_SKP_B) ? i_cfg_data : r_skp_b;
    assign n_skp_c = (i_cfg_we && i_cfg_index == REG_SKP_C) ? i_cfg_data : r_skp_c;

    // Status toward the controller
    always_comb begin
        o_status.triple = w_triple;
        o_status.done   = r_done;
        o_status.in_b   = r_inb;
        o_status.in_c   = r_inc;
        o_status.a_end  = w_triple ? (r_a >= r_end[0]) : (r_a >= w_right_a);
        o_status.a_skip = in_skip(r_a, w_ex_a);
        o_status.b_end  = w_triple ? (r_b >= r_end[1]) : (r_b >= w_right_b);
        o_status.c_end  = r_c >= r_end[2];
        o_status.ab_bad = w_triple
            ? (in_skip(r_a, r_skp[0]) || in_skip(r_b, r_skp[1]) || !w_far)
            : (in_skip(r_b, w_ex_b) || !w_far);
        o_status.bc_bad = in_skip(r_c, r_skp[2]) || !w_far;
    end

    // Triple-mode border exchange on entry of a new a
    logic [16:0] e0, e1, e2, t17;
    logic [33:0] s0, s1, s2, t34;
    always_comb begin
        e0 = r_end[0]; e1 = r_end[1]; e2 = r_end[2];
        s0 = r_skp[0]; s1 = r_skp[1]; s2 = r_skp[2];
        t17 = '0; t34 = '0;
        if (r_a >= w_first_b && e1 < e0) begin
            t17 = e0; e0 = e1; e1 = t17; t34 = s0; s0 = s1; s1 = t34;
        end
        if (r_a >= w_first_c && e2 < e1) begin
            t17 = e1; e1 = e2; e2 = t17; t34 = s1; s1 = s2; s2 = t34;
            if (e1 < e0) begin
                t17 = e0; e0 = e1; e1 = t17; t34 = s0; s0 = s1; s1 = t34;
            end
        end
    end

    // Configuration writes and restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 2'd2;
            r_rng_a <= '0; r_rng_b <= '0; r_rng_c <= '0;
            r_skp_a <= '0; r_skp_b <= '0; r_skp_c <= '0;
            r_mdist <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ORDER: r_order <= i_cfg_data[1:0];
                REG_RNG_A: r_rng_a <= i_cfg_data;
                REG_RNG_B: r_rng_b <= i_cfg_data;
                REG_RNG_C: r_rng_c <= i_cfg_data;
                REG_SKP_A: r_skp_a <= i_cfg_data;
                REG_SKP_B: r_skp_b <= i_cfg_data;
                REG_SKP_C: r_skp_c <= i_cfg_data;
                REG_MDIST: r_mdist <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Loop indices and flags
    always_ff @(posedge i_clk) begin
        r_p_ok <= (w_p < 17'(SNP_COUNT));
        r_q_ok <= (w_q < 17'(SNP_COUNT));
        if (!i_rst_n || i_cmd.restart) begin
            r_a    <= i_rst_n ? n_rng_a[16:0] : 17'd0;
            r_b    <= '0;
            r_c    <= '0;
            r_end[0] <= i_rst_n ? n_rng_a[33:17] : 17'd0;
            r_end[1] <= i_rst_n ? n_rng_b[33:17] : 17'd0;
            r_end[2] <= i_rst_n ? n_rng_c[33:17] : 17'd0;
            r_skp[0] <= i_rst_n ? n_skp_a : 34'd0;
            r_skp[1] <= i_rst_n ? n_skp_b : 34'd0;
            r_skp[2] <= i_rst_n ? n_skp_c : 34'd0;
            r_done <= 1'b0; r_inb <= 1'b0; r_inc <= 1'b0; r_swbc <= 1'b0;
            r_fill <= '0;
            r_oh <= 1'b0; r_obe <= 1'b0; r_ofin <= 1'b0;
        end else begin
            if (i_cmd.enter_a) begin
                if (w_triple) begin
                    r_end[0] <= e0; r_end[1] <= e1; r_end[2] <= e2;
                    r_skp[0] <= s0; r_skp[1] <= s1; r_skp[2] <= s2;
                    r_swbc <= 1'b0;
                    r_inc  <= 1'b0;
                end
                r_b   <= max17(w_first_b, r_a + 17'd1);
                r_inb <= 1'b1;
            end
            if (i_cmd.adv_a) begin
                if (r_swbc) begin
                    r_end[1] <= r_end[2]; r_end[2] <= r_end[1];
                    r_skp[1] <= r_skp[2]; r_skp[2] <= r_skp[1];
                end
                r_swbc <= 1'b0;
                r_inb  <= 1'b0;
                r_a    <= r_a + 17'd1;
            end
            // Exchange B and C once per a once b reaches set C
            if (i_cmd.rd_ab && w_triple && r_b >= w_first_c && r_end[2] < r_end[1]) begin
                r_end[1] <= r_end[2]; r_end[2] <= r_end[1];
                r_skp[1] <= r_skp[2]; r_skp[2] <= r_skp[1];
                r_swbc <= 1'b1;
            end
            if (i_cmd.enter_b) begin
                r_c   <= max17(w_first_c, r_b + 17'd1);
                r_inc <= 1'b1;
            end
            if (i_cmd.adv_b) begin
                r_b   <= r_b + 17'd1;
                r_inc <= 1'b0;
            end
            if (i_cmd.adv_c) begin
                r_c <= r_c + 17'd1;
            end
            if (i_cmd.emit) begin
                r_o1 <= r_a[15:0];
                r_o2 <= r_b[15:0];
                r_o3 <= w_triple ? r_c[15:0] : 16'd0;
                r_oh <= 1'b1; r_ofin <= 1'b0;
                if (r_fill + FCW'(1) >= FCW'(IDS_PER_BUFFER)) begin
                    r_fill <= '0; r_obe <= 1'b1;
                end else begin
                    r_fill <= r_fill + FCW'(1); r_obe <= 1'b0;
                end
            end
            if (i_cmd.fin) begin
                r_done <= 1'b1;
                r_o1 <= '0; r_o2 <= '0; r_o3 <= '0;
                r_oh <= 1'b0; r_obe <= 1'b0; r_ofin <= 1'b1;
            end
        end
    end

    assign o_first_id   = r_o1;
    assign o_second_id  = r_o2;
    assign o_third_id   = r_o3;
    assign o_has_tuple  = r_oh;
    assign o_buffer_end = r_obe;
    assign o_finished   = r_ofin;
endmodule : snpce_datapath
`default_nettype wire

>>> sv/snpce_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snpce_ctrl
// Controller of the enumerator: takes commands, steps the loops one move per
// cycle unless a result waits, waits for table reads and fills the output register.
// ----------------------------------------------------------------------------
module snpce_ctrl import snpce_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_command,
    output logic             o_valid,
    input  wire logic        i_ready,
    input  wire t_dp_status  i_status,
    output t_dp_cmd          o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_STEP = 5'b00010,
        S_RDAB = 5'b00100,
        S_RDBC = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Accept only when idle and no result is waiting
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        o_cmd.restart = i_cfg_we;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_command)
                        CMD_LOAD: o_cmd.load = 1'b1;
                        CMD_ABORT: begin
                            o_cmd.fin = 1'b1; n_state = S_OUT;
                        end
                        CMD_NEXT: begin
                            if (i_status.done) begin
                                o_cmd.fin = 1'b1; n_state = S_OUT;
                            end else begin
                                n_state = S_STEP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_STEP: begin
                if (!i_status.in_b) begin
                    if (i_status.a_end) begin
                        o_cmd.fin = 1'b1; n_state = S_OUT;
                    end else if (!i_status.triple && i_status.a_skip) begin
                        o_cmd.adv_a = 1'b1;
                    end else begin
                        o_cmd.enter_a = 1'b1;
                    end
                end else if (!i_status.triple || !i_status.in_c) begin
                    if (i_status.b_end) begin
                        o_cmd.adv_a = 1'b1;
                    end else begin
                        o_cmd.rd_ab = 1'b1; n_state = S_RDAB;
                    end
                end else begin
                    if (i_status.c_end) begin
                        o_cmd.adv_b = 1'b1;
                    end else begin
                        o_cmd.rd_bc = 1'b1; n_state = S_RDBC;
                    end
                end
            end
            S_RDAB: begin
                n_state = S_STEP;
                if (!i_status.triple) begin
                    o_cmd.adv_b = 1'b1;
                    if (!i_status.ab_bad) begin
                        o_cmd.emit = 1'b1; n_state = S_OUT;
                    end
                end else if (i_status.ab_bad) begin
                    o_cmd.adv_b = 1'b1;
                end else begin
                    o_cmd.enter_b = 1'b1;
                end
            end
            S_RDBC: begin
                n_state = S_STEP;
                o_cmd.adv_c = 1'b1;
                if (!i_status.bc_bad) begin
                    o_cmd.emit = 1'b1; n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_we) n_state = S_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule : snpce_ctrl
`default_nettype wire

>>> sv/snpce_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snpce_checker
// Port-level checks of the enumerator core, bound to the top level.
// ----------------------------------------------------------------------------
module snpce_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [15:0] o_first_id,
    input wire logic [15:0] o_second_id,
    input wire logic        o_has_tuple,
    input wire logic        o_buffer_end,
    input wire logic        o_finished
);
    // A result is a tuple or a finished mark, never both
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_has_tuple != o_finished))
        else $error("result neither tuple nor finished");

    // Buffer end only on a delivered tuple
    a_bend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_buffer_end) |-> o_has_tuple)
        else $error("buffer end without tuple");

    // Tuples have distinct first and second ids
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_has_tuple) |-> (o_second_id != o_first_id))
        else $error("degenerate pair");

    // Pending result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_first_id)))
        else $error("result dropped while stalled");

    // No new item is taken while a result waits
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("input ready while result pending");
endmodule : snpce_checker

bind snp_combination_enumerator_core snpce_checker u_snpce_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_first_id(o_first_id),
    .o_second_id(o_second_id), .o_has_tuple(o_has_tuple),
    .o_buffer_end(o_buffer_end), .o_finished(o_finished));
`default_nettype wire
